// File: rtl/bsd_pkg.sv
// ----------------------------------------------------------------------------
// bsd_pkg
// Types, character constants and hex helpers for the backslash escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bsd_pkg;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESC    = 2'd1,
      MODE_HEX0   = 2'd2,
      MODE_HEX1   = 2'd3
   } mode_type;

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] BYTE_LF   = 8'd10;
   localparam logic [7:0] BYTE_CR   = 8'd13;
   localparam logic [7:0] BYTE_TAB  = 8'd9;
   localparam logic [7:0] BYTE_NUL  = 8'd0;

   localparam int BUNDLE_SLOTS = 3;

   // one result
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       string_done;
   } slot_type;

   // all results of one request, cnt is 1..3
   typedef struct packed {
      slot_type [BUNDLE_SLOTS-1:0] slot;
      logic [1:0]                  cnt;
   } bundle_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic is_hex(input logic [7:0] ch);
      logic dig, lo, up;
      dig = (ch >= 8'h30) && (ch <= 8'h39);
      lo  = (ch >= 8'h61) && (ch <= 8'h66);
      up  = (ch >= 8'h41) && (ch <= 8'h46);
      return dig | lo | up;
   endfunction

   // caller guarantees is_hex(ch)
   function automatic logic [3:0] hex_val(input logic [7:0] ch);
      logic [7:0] v;
      if (ch <= 8'h39) begin
         v = ch - 8'h30;
      end else if (ch >= 8'h61) begin
         v = ch - 8'h57;
      end else begin
         v = ch - 8'h37;
      end
      return v[3:0];
   endfunction

   function automatic slot_type byte_slot(input logic [7:0] b);
      slot_type s;
      s.out_byte    = b;
      s.byte_valid  = 1'b1;
      s.string_done = 1'b0;
      return s;
   endfunction

   function automatic slot_type done_slot();
      slot_type s;
      s.out_byte    = 8'd0;
      s.byte_valid  = 1'b0;
      s.string_done = 1'b1;
      return s;
   endfunction

endpackage

`default_nettype wire

// File: rtl/bsd_if.sv
// ----------------------------------------------------------------------------
// bsd_if
// Valid/ready channels for request and response of the escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_marker;

   modport source (output valid, output in_byte, output end_marker, input ready);
   modport sink   (input valid, input in_byte, input end_marker, output ready);
endinterface

interface bsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       string_done;
   logic       run_last;

   modport source (output valid, output out_byte, output byte_valid,
                   output string_done, output run_last, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input string_done, input run_last, output ready);
endinterface

`default_nettype wire

// File: rtl/backslash_escape_decoder_top.sv
// ----------------------------------------------------------------------------
// backslash_escape_decoder_top
// Streaming decoder for C-style backslash escapes, one character per request.
//
//   channel   dir   handshake      payload
//   req_ch    in    valid/ready    in_byte[7:0], end_marker
//   rsp_ch    out   valid/ready    out_byte[7:0], byte_valid, string_done, run_last
//
// A request is taken every cycle while the bundle queue has room; it yields
// 0 to 3 responses, which leave one per cycle while rsp_ch is ready, from a registered output.
// Sustained rate: 1 request per cycle when it averages at most one response,
// otherwise bounded by the single response port (one response per cycle).
// A request's first response is registered in the queue, then in the output register.
// Synchronous reset puts the decoder in normal mode and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module backslash_escape_decoder_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   bsd_req_if.sink   req_ch,
   bsd_rsp_if.source rsp_ch
);
   import bsd_pkg::*;

   logic             push, pop;
   bundle_type       push_data, head;
   queue_status_type q_status;

   bsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   bsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   bsd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_ch)
   );

endmodule

`default_nettype wire

// File: rtl/bsd_front.sv
// ----------------------------------------------------------------------------
// bsd_front
// Accepts requests, tracks the escape mode and builds the result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   bsd_req_if.sink                        req,
   input  wire bsd_pkg::queue_status_type q_status,
   output      logic                      push,
   output      bsd_pkg::bundle_type       push_data
);
   import bsd_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [7:0] held_ff, held_in;
   logic       accept;
   logic       ch_hex;
   logic [7:0] ch;
   bundle_type bnd;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;
   assign ch        = req.in_byte;
   assign ch_hex    = is_hex(ch);

   // next state
   always_comb begin
      mode_in = mode_ff;
      held_in = held_ff;
      if (accept) begin
         if (req.end_marker) begin
            mode_in = MODE_NORMAL;
            held_in = 8'd0;
         end else begin
            unique case (mode_ff)
               MODE_NORMAL: begin
                  mode_in = (ch == CH_BSLASH) ? MODE_ESC : MODE_NORMAL;
               end
               MODE_ESC: begin
                  mode_in = (ch == CH_X) ? MODE_HEX0 : MODE_NORMAL;
               end
               MODE_HEX0: begin
                  if (ch_hex) begin
                     mode_in = MODE_HEX1;
                     held_in = ch;
                  end else begin
                     mode_in = (ch == CH_BSLASH) ? MODE_ESC : MODE_NORMAL;
                  end
               end
               MODE_HEX1: begin
                  held_in = 8'd0;
                  if (ch_hex) begin
                     mode_in = MODE_NORMAL;
                  end else begin
                     mode_in = (ch == CH_BSLASH) ? MODE_ESC : MODE_NORMAL;
                  end
               end
               default: mode_in = MODE_NORMAL;
            endcase
         end
      end
   end

   // results of this request
   always_comb begin
      bnd = '0;
      if (req.end_marker) begin
         unique case (mode_ff)
            MODE_NORMAL: begin
               bnd.slot[0] = done_slot();
               bnd.cnt     = 2'd1;
            end
            MODE_ESC: begin
               bnd.slot[0] = byte_slot(CH_BSLASH);
               bnd.slot[1] = done_slot();
               bnd.cnt     = 2'd2;
            end
            MODE_HEX0: begin
               bnd.slot[0] = byte_slot(CH_X);
               bnd.slot[1] = done_slot();
               bnd.cnt     = 2'd2;
            end
            MODE_HEX1: begin
               bnd.slot[0] = byte_slot(CH_X);
               bnd.slot[1] = byte_slot(held_ff);
               bnd.slot[2] = done_slot();
               bnd.cnt     = 2'd3;
            end
            default: bnd = '0;
         endcase
      end else begin
         unique case (mode_ff)
            MODE_NORMAL: begin
               if (ch != CH_BSLASH) begin
                  bnd.slot[0] = byte_slot(ch);
                  bnd.cnt     = 2'd1;
               end
            end
            MODE_ESC: begin
               unique case (ch)
                  CH_N:    bnd.slot[0] = byte_slot(BYTE_LF);
                  CH_R:    bnd.slot[0] = byte_slot(BYTE_CR);
                  CH_T:    bnd.slot[0] = byte_slot(BYTE_TAB);
                  CH_ZERO: bnd.slot[0] = byte_slot(BYTE_NUL);
                  default: bnd.slot[0] = byte_slot(ch);
               endcase
               bnd.cnt = (ch == CH_X) ? 2'd0 : 2'd1;
            end
            MODE_HEX0: begin
               if (!ch_hex) begin
                  bnd.slot[0] = byte_slot(CH_X);
                  bnd.slot[1] = byte_slot(ch);
                  bnd.cnt     = (ch == CH_BSLASH) ? 2'd1 : 2'd2;
               end
            end
            MODE_HEX1: begin
               if (ch_hex) begin
                  bnd.slot[0] = byte_slot({hex_val(held_ff), hex_val(ch)});
                  bnd.cnt     = 2'd1;
               end else begin
                  bnd.slot[0] = byte_slot(CH_X);
                  bnd.slot[1] = byte_slot(held_ff);
                  bnd.slot[2] = byte_slot(ch);
                  bnd.cnt     = (ch == CH_BSLASH) ? 2'd2 : 2'd3;
               end
            end
            default: bnd = '0;
         endcase
      end
   end

   assign push      = accept && (bnd.cnt != 2'd0);
   assign push_data = bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         held_ff <= 8'd0;
      end else begin
         mode_ff <= mode_in;
         held_ff <= held_in;
      end
   end

   a_end_clears_state: assert property (@(posedge clock) disable iff (reset)
      accept && req.end_marker |=> mode_ff == MODE_NORMAL && held_ff == 8'd0)
      else $error("end marker did not return decoder to normal mode");

   a_end_pushes: assert property (@(posedge clock) disable iff (reset)
      accept && req.end_marker |-> push && push_data.slot[push_data.cnt - 2'd1].string_done)
      else $error("end marker must push a bundle ending in string done");

   a_hex1_holds_digit: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_HEX1 |-> is_hex(held_ff))
      else $error("held digit is not a hex character");

endmodule

`default_nettype wire

// File: rtl/bsd_queue.sv
// ----------------------------------------------------------------------------
// bsd_queue
// Small bundle queue between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire bsd_pkg::bundle_type        push_data,
   input  wire logic                       pop,
   output      bsd_pkg::bundle_type        head,
   output      bsd_pkg::queue_status_type  status
);
   import bsd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   bundle_type    mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_CNT);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance on push");

endmodule

`default_nettype wire

// File: rtl/bsd_back.sv
// ----------------------------------------------------------------------------
// bsd_back
// Unrolls queued bundles into one registered response per cycle while rsp is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire bsd_pkg::bundle_type       head,
   input  wire bsd_pkg::queue_status_type q_status,
   output      logic                      pop,
   bsd_rsp_if.source                      rsp
);
   import bsd_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   slot_type   slot_ff, slot_in;
   logic       last_ff, last_in;
   logic       load, is_last;

   assign load    = (!valid_ff || rsp.ready) && !q_status.empty;
   assign is_last = (idx_ff == head.cnt - 2'd1);
   assign pop     = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      slot_in  = slot_ff;
      last_in  = last_ff;
      if (rsp.ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         slot_in  = head.slot[idx_ff];
         last_in  = is_last;
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      last_ff <= last_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.out_byte    = slot_ff.out_byte;
   assign rsp.byte_valid  = slot_ff.byte_valid;
   assign rsp.string_done = slot_ff.string_done;
   assign rsp.run_last    = last_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.string_done |-> rsp.run_last && !rsp.byte_valid)
      else $error("string done must be the last result and carry no byte");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> idx_ff < head.cnt)
      else $error("slot index beyond bundle count");

   a_idx_rewinds: assert property (@(posedge clock) disable iff (reset)
      pop |=> idx_ff == 2'd0)
      else $error("slot index not rewound after pop");

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for backslash_escape_decoder_top. A short table of directed
// escapes and end-of-string flushes is followed by random strings, mostly
// well formed with some broken hex escapes and stray bytes. Every accepted
// request goes through a local decoder model. Each response is compared
// field by field against the oldest pending decoded result. Both channels
// idle at random, and the response side is held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bsd_pkg::*;

   localparam int DIR_ROWS         = 34;
   localparam int RANDOM_PER_STAGE = 78;
   localparam int LONG_STALL       = 80;
   localparam int DRAIN_CYCLES     = 16;
   localparam int CYCLE_LIMIT      = 100000;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       string_done;
      logic       run_last;
   } rsp_t;

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } char_req_t;

   // chk set: the bytes below, plus string done on an end row, are the whole answer for the row
   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
      logic       chk;
      logic [1:0] nb;
      logic [7:0] b0;
      logic [7:0] b1;
   } dir_row_t;

   dir_row_t dir_tbl [DIR_ROWS] = '{
      '{8'hFF,     1'b0, 1'b1, 2'd1, 8'hFF,     8'h00},
      '{8'h00,     1'b0, 1'b1, 2'd1, 8'h00,     8'h00},  // NUL is an ordinary char
      '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,     8'h00},
      '{CH_N,      1'b0, 1'b1, 2'd1, BYTE_LF,   8'h00},
      '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,     8'h00},
      '{CH_R,      1'b0, 1'b1, 2'd1, BYTE_CR,   8'h00},
      '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,     8'h00},
      '{CH_T,      1'b0, 1'b1, 2'd1, BYTE_TAB,  8'h00},
      '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,     8'h00},
      '{CH_ZERO,   1'b0, 1'b1, 2'd1, BYTE_NUL,  8'h00},
      '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,     8'h00},
      '{CH_BSLASH, 1'b0, 1'b1, 2'd1, CH_BSLASH, 8'h00},
      '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,     8'h00},
      '{"q",       1'b0, 1'b0, 2'd0, 8'h00,     8'h00},
      '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00,     8'h00},
      '{CH_X,      1'b0, 1'b1, 2'd0, 8'h00,     8'h00},
      '{"4",       1'b0, 1'b0, 2'd0, 8'h00,     8'h00},
      '{"f",       1'b0, 1'b0, 2'd0, 8'h00,     8'h00},
      // \x with one digit, then a non-hex char
      '{CH_BSLASH, 1'b0, 1'b0, 2'd0, 8'h00,     8'h00},
      '{CH_X,      1'b0, 1'b0, 2'd0, 8'h00,     8'h00},
      '{"B",       1'b0, 1'b0, 2'd0, 8'h00,     8'h00},
      '{"z",       1'b0, 1'b0, 2'd0, 8'h00,     8'h00},
      // \x with no digit, and the next backslash opens a new escape
      '{CH_BSLASH, 1'b0, 1'b0, 2'd0, 8'h00,     8'h00},
      '{CH_X,      1'b0, 1'b0, 2'd0, 8'h00,     8'h00},
      '{CH_BSLASH, 1'b0, 1'b0, 2'd0, 8'h00,     8'h00},
      '{CH_N,      1'b1, 1'b1, 2'd1, CH_BSLASH, 8'h00},  // trailing backslash
      '{CH_BSLASH, 1'b0, 1'b0, 2'd0, 8'h00,     8'h00},
      '{CH_X,      1'b0, 1'b0, 2'd0, 8'h00,     8'h00},
      '{"C",       1'b0, 1'b0, 2'd0, 8'h00,     8'h00},
      '{8'h00,     1'b1, 1'b1, 2'd2, CH_X,      "C"},
      '{CH_BSLASH, 1'b0, 1'b0, 2'd0, 8'h00,     8'h00},
      '{CH_X,      1'b0, 1'b0, 2'd0, 8'h00,     8'h00},
      '{8'hFF,     1'b1, 1'b1, 2'd1, CH_X,      8'h00},
      '{CH_BSLASH, 1'b1, 1'b1, 2'd0, 8'h00,     8'h00}
   };

   string hex_chars = "0123456789abcdefABCDEF";

   logic clock;
   logic reset;

   bsd_req_if req_ch ();
   bsd_rsp_if rsp_ch ();

   backslash_escape_decoder_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // decoder model state
   mode_type   dec_mode;
   logic [7:0] dec_held;
   rsp_t       pred_res [3];

   rsp_t      decoded_due [$];
   char_req_t stim_q [$];

   int stage;
   int send_idle_pct;
   int rsp_idle_pct;
   int fail_count;
   int req_count;
   int rsp_count;
   int done_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("backslash_escape_decoder_top verification failed");
      $finish;
   end

   function automatic int nibble_of(input logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return int'(ch) - int'(8'h30);
      if (ch >= "a" && ch <= "f") return int'(ch) - int'(8'h61) + 10;
      if (ch >= "A" && ch <= "F") return int'(ch) - int'(8'h41) + 10;
      return -1;
   endfunction

   function automatic int emit(input int n, input logic [7:0] b, input logic v,
                               input logic d);
      pred_res[n] = '{out_byte: b, byte_valid: v, string_done: d, run_last: 1'b0};
      return n + 1;
   endfunction

   function automatic int plain_char(input int n, input logic [7:0] ch);
      if (ch == CH_BSLASH) begin
         dec_mode = MODE_ESC;
         return n;
      end
      dec_mode = MODE_NORMAL;
      return emit(n, ch, 1'b1, 1'b0);
   endfunction

   // fills pred_res with the results of one request, returns their count
   function automatic int decode_char(input logic [7:0] ch, input logic fin);
      int n;
      int lo;
      int hi;
      n = 0;
      if (fin) begin
         case (dec_mode)
            MODE_ESC:  n = emit(n, CH_BSLASH, 1'b1, 1'b0);
            MODE_HEX0: n = emit(n, CH_X, 1'b1, 1'b0);
            MODE_HEX1: begin
               n = emit(n, CH_X, 1'b1, 1'b0);
               n = emit(n, dec_held, 1'b1, 1'b0);
            end
            default: ;
         endcase
         n = emit(n, 8'd0, 1'b0, 1'b1);
         dec_mode = MODE_NORMAL;
         dec_held = 8'd0;
      end else begin
         case (dec_mode)
            MODE_NORMAL: n = plain_char(n, ch);
            MODE_ESC: begin
               dec_mode = MODE_NORMAL;
               case (ch)
                  CH_N:    n = emit(n, BYTE_LF, 1'b1, 1'b0);
                  CH_R:    n = emit(n, BYTE_CR, 1'b1, 1'b0);
                  CH_T:    n = emit(n, BYTE_TAB, 1'b1, 1'b0);
                  CH_ZERO: n = emit(n, BYTE_NUL, 1'b1, 1'b0);
                  CH_X:    dec_mode = MODE_HEX0;
                  default: n = emit(n, ch, 1'b1, 1'b0);
               endcase
            end
            MODE_HEX0: begin
               if (nibble_of(ch) >= 0) begin
                  dec_held = ch;
                  dec_mode = MODE_HEX1;
               end else begin
                  n = emit(n, CH_X, 1'b1, 1'b0);
                  n = plain_char(n, ch);
               end
            end
            default: begin
               lo = nibble_of(ch);
               if (lo >= 0) begin
                  hi = nibble_of(dec_held);
                  if (hi < 0) hi = 0;
                  n = emit(n, 8'(hi * 16 + lo), 1'b1, 1'b0);
                  dec_mode = MODE_NORMAL;
               end else begin
                  n = emit(n, CH_X, 1'b1, 1'b0);
                  n = emit(n, dec_held, 1'b1, 1'b0);
                  n = plain_char(n, ch);
               end
               dec_held = 8'd0;
            end
         endcase
      end
      if (n > 0) pred_res[n-1].run_last = 1'b1;
      return n;
   endfunction

   function automatic logic [7:0] rand_hex();
      return hex_chars[$urandom_range(21)];
   endfunction

   function automatic logic [7:0] rand_nonhex();
      logic [7:0] c;
      c = 8'($urandom_range(255, 1));
      while (nibble_of(c) >= 0) c = 8'($urandom_range(255, 1));
      return c;
   endfunction

   function automatic void push_char(input logic [7:0] c);
      stim_q.push_back('{ch: c, fin: 1'b0});
   endfunction

   // one random string: a few tokens, sometimes an unfinished escape, then end
   function automatic void add_string();
      int         tokens;
      int         kind;
      logic [7:0] c;
      tokens = $urandom_range(6, 1);
      repeat (tokens) begin
         kind = $urandom_range(99);
         if (kind < 40) begin
            c = 8'($urandom_range(255, 1));
            if (c == CH_BSLASH) c = 8'h5B;
            push_char(c);
         end else if (kind < 55) begin
            push_char(CH_BSLASH);
            case ($urandom_range(5))
               0: c = CH_N;
               1: c = CH_R;
               2: c = CH_T;
               3: c = CH_ZERO;
               4: c = CH_BSLASH;
               default: begin
                  c = 8'($urandom_range(255, 1));
                  if (c == CH_X) c = 8'h79;
               end
            endcase
            push_char(c);
         end else if (kind < 80) begin
            push_char(CH_BSLASH);
            push_char(CH_X);
            push_char(rand_hex());
            push_char(rand_hex());
         end else if (kind < 88) begin
            push_char(CH_BSLASH);
            push_char(CH_X);
            push_char(rand_hex());
            push_char(($urandom_range(3) == 0) ? CH_BSLASH : rand_nonhex());
         end else if (kind < 93) begin
            push_char(CH_BSLASH);
            push_char(CH_X);
            push_char(rand_nonhex());
         end else begin
            push_char(8'($urandom_range(255, 1)));
         end
      end
      kind = $urandom_range(99);
      if (kind < 20) push_char(CH_BSLASH);
      if (kind < 14) push_char(CH_X);
      if (kind < 7)  push_char(rand_hex());
      stim_q.push_back('{ch: 8'($urandom_range(255)), fin: 1'b1});
   endfunction

   task automatic send_request(input logic [7:0] ch, input logic fin, input logic chk,
                               input logic [1:0] nb, input logic [7:0] b0,
                               input logic [7:0] b1);
      int n;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.in_byte    <= ch;
      req_ch.end_marker <= fin;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      req_count++;
      n = decode_char(ch, fin);
      if (chk) begin
         n = int'(nb) + int'(fin);
         for (int k = 0; k < int'(nb); k++) begin
            pred_res[k] = '{out_byte: (k == 0) ? b0 : b1, byte_valid: 1'b1,
                            string_done: 1'b0, run_last: 1'b0};
         end
         if (fin) begin
            pred_res[nb] = '{out_byte: 8'd0, byte_valid: 1'b0, string_done: 1'b1,
                             run_last: 1'b0};
         end
         if (n > 0) pred_res[n-1].run_last = 1'b1;
      end
      for (int k = 0; k < n; k++) decoded_due.push_back(pred_res[k]);
   endtask

   // response side: check at each edge, then pick next ready
   initial begin
      rsp_t want;
      int   stall_left;
      bit   stall_done;
      stall_left = 0;
      stall_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            rsp_count++;
            if (rsp_ch.string_done === 1'b1) done_count++;
            if (decoded_due.size() == 0) begin
               $error("response with nothing expected: out_byte %02h", rsp_ch.out_byte);
               fail_count++;
            end else begin
               want = decoded_due.pop_front();
               if (rsp_ch.out_byte !== want.out_byte) begin
                  $error("out_byte expected %02h actual %02h", want.out_byte,
                         rsp_ch.out_byte);
                  fail_count++;
               end
               if (rsp_ch.byte_valid !== want.byte_valid) begin
                  $error("byte_valid expected %0b actual %0b", want.byte_valid,
                         rsp_ch.byte_valid);
                  fail_count++;
               end
               if (rsp_ch.string_done !== want.string_done) begin
                  $error("string_done expected %0b actual %0b", want.string_done,
                         rsp_ch.string_done);
                  fail_count++;
               end
               if (rsp_ch.run_last !== want.run_last) begin
                  $error("run_last expected %0b actual %0b", want.run_last,
                         rsp_ch.run_last);
                  fail_count++;
               end
            end
         end
         // one long hold-off while the sender keeps pushing, to back up the queue
         if (stage == 2 && !stall_done) begin
            stall_left = LONG_STALL;
            stall_done = 1'b1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.in_byte    <= 8'd0;
      req_ch.end_marker <= 1'b0;
      dec_mode      = MODE_NORMAL;
      dec_held      = 8'd0;
      stage         = 0;
      send_idle_pct = 20;
      rsp_idle_pct  = 47;
      fail_count    = 0;
      req_count     = 0;
      rsp_count     = 0;
      done_count    = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tbl[i]) begin
         send_request(dir_tbl[i].ch, dir_tbl[i].fin, dir_tbl[i].chk, dir_tbl[i].nb,
                      dir_tbl[i].b0, dir_tbl[i].b1);
      end

      for (int s = 0; s < 3; s++) begin
         if (s == 1) begin
            send_idle_pct = 47;
            rsp_idle_pct  = 20;
         end else if (s == 2) begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         stage = s;
         stim_q.delete();
         while (stim_q.size() < RANDOM_PER_STAGE) add_string();
         foreach (stim_q[i]) begin
            send_request(stim_q[i].ch, stim_q[i].fin, 1'b0, 2'd0, 8'd0, 8'd0);
         end
         req_ch.valid <= 1'b0;
         // sender waits here for every response of the stage
         while (decoded_due.size() != 0) @(posedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Summary: %0d requests (escapes, hex, broken hex, end flushes, random)",
               req_count);
      $display("         %0d responses checked, %0d strings closed, %0d-cycle stall",
               rsp_count, done_count, LONG_STALL);
      if (fail_count == 0) begin
         $display("backslash_escape_decoder_top verification clean");
      end else begin
         $display("backslash_escape_decoder_top verification failed");
      end
      $finish;
   end

endmodule
